>>> hw/rtl/sparse_triplet_merge_add_unit_defines.svh
// assertion macros for the sparse triplet merge add unit
`ifndef SPARSE_TRIPLET_MERGE_ADD_UNIT_DEFINES_SVH
`define SPARSE_TRIPLET_MERGE_ADD_UNIT_DEFINES_SVH

// property that holds at every clock edge out of reset
`define STMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define STMA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/stma_pkg.sv
// types and constants of the sparse triplet merge add unit
`default_nettype none

package stma_pkg;

    // input commands
    localparam logic [2:0] CMD_HDR_A  = 3'd0;
    localparam logic [2:0] CMD_HDR_B  = 3'd1;
    localparam logic [2:0] CMD_TERM_A = 3'd2;
    localparam logic [2:0] CMD_TERM_B = 3'd3;
    localparam logic [2:0] CMD_START  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TERM    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_INCOMP  = 2'd2;

    localparam int DIM_W   = 12;
    localparam int VAL_W   = 16;
    localparam int SUM_W   = 17;
    localparam int CNT_W   = 6;
    localparam int LIN_W   = 2 * DIM_W + 1;

    // one stored triplet, row in the lowest bits
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [DIM_W-1:0]        col;
        logic [DIM_W-1:0]        row;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_RD    = 5'b00100,
        S_MUL   = 5'b01000,
        S_CMP   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/stma_ram.sv
// generic single write port ram with registered read
`default_nettype none

module stma_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/sparse_triplet_merge_add_unit.sv
// Sparse matrix addition: two triplet lists are loaded, a start command
// merges them by linear index and streams the result terms.
//
// Input channel s_*: one command per item. Headers and term loads are taken
// in one cycle each while the unit is idle. A start command holds s_tready
// low until its last result has been written into the output register.
// Output channel m_*: result terms, then a summary with m_tlast set, or a
// single incompatible-dimensions result with m_tlast set.
// An incompatible result is issued from the start state; a merge runs the
// states ram read, multiply for the linear index, and compare and emit for
// each term, and gives the summary once both lists are used up. Term
// storage is one ram per matrix with one read and one write port and a
// registered read.
// Reset (rst_n low, asynchronous) clears dimensions, counts, the dropped
// flag and the output valid flag; stored terms are left as they are.
// A stalled receiver (m_tready low) holds the output register, and the
// merge waits on it without losing or repeating a term.
`default_nettype none

module sparse_triplet_merge_add_unit #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // row[11:0], col[23:12], value[39:24]
    input  wire logic [2:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // out_row[11:0], out_col[23:12],
                                        // sum_value[40:24], term_count[46:41],
                                        // overflow[47]
    output logic      [1:0]  m_tuser,   // kind
    output logic             m_tlast    // last
);

`include "sparse_triplet_merge_add_unit_defines.svh"

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int DW = stma_pkg::DIM_W;
    localparam int LW = stma_pkg::LIN_W;
    localparam int EW = $bits(stma_pkg::entry_t);

    stma_pkg::state_t state_reg, state_next;

    logic [DW-1:0] a_rows_reg, a_rows_next, a_cols_reg, a_cols_next;
    logic [DW-1:0] b_rows_reg, b_rows_next, b_cols_reg, b_cols_next;
    logic [CW-1:0] a_count_reg, a_count_next, b_count_reg, b_count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [stma_pkg::CNT_W-1:0] n_reg, n_next;
    logic          dropped_reg, dropped_next;
    logic [LW-1:0] xi_reg, xi_next, yi_reg, yi_next;

    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_kind_reg, m_kind_next;
    logic [DW-1:0]                m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic signed [stma_pkg::SUM_W-1:0] m_sum_reg, m_sum_next;
    logic [stma_pkg::CNT_W-1:0]   m_cnt_reg, m_cnt_next;
    logic                         m_ovf_reg, m_ovf_next;
    logic                         m_last_reg, m_last_next;

    logic             a_we, b_we;
    logic [EW-1:0]    a_rdata, b_rdata;
    stma_pkg::entry_t a_ent, b_ent, in_ent;
    logic [2*DW-1:0]  prod_a, prod_b;
    logic             have_a, have_b, use_a, use_b, slot_free;
    logic signed [stma_pkg::SUM_W-1:0] a_ext, b_ext;

    assign in_ent = stma_pkg::entry_t'(s_tdata);
    assign a_ent  = stma_pkg::entry_t'(a_rdata);
    assign b_ent  = stma_pkg::entry_t'(b_rdata);

    stma_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS), .AW(AW)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (i_reg[AW-1:0]),
        .rdata (a_rdata)
    );

    stma_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS), .AW(AW)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_count_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (j_reg[AW-1:0]),
        .rdata (b_rdata)
    );

    assign have_a    = (i_reg < a_count_reg);
    assign have_b    = (j_reg < b_count_reg);
    assign slot_free = !m_valid_reg || m_tready;

    // linear index row * cols + col, registered before the compare
    assign prod_a = {{DW{1'b0}}, a_ent.row} * {{DW{1'b0}}, a_cols_reg};
    assign prod_b = {{DW{1'b0}}, b_ent.row} * {{DW{1'b0}}, b_cols_reg};

    // equal indices select both sides and give the sum
    assign use_a = have_a && (!have_b || (xi_reg <= yi_reg));
    assign use_b = have_b && (!have_a || (yi_reg <= xi_reg));
    assign a_ext = use_a ? {a_ent.value[stma_pkg::VAL_W-1], a_ent.value} : '0;
    assign b_ext = use_b ? {b_ent.value[stma_pkg::VAL_W-1], b_ent.value} : '0;

    always_comb
    begin
        state_next   = state_reg;
        a_rows_next  = a_rows_reg;
        a_cols_next  = a_cols_reg;
        b_rows_next  = b_rows_reg;
        b_cols_next  = b_cols_reg;
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        dropped_next = dropped_reg;
        xi_next      = xi_reg;
        yi_next      = yi_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_sum_next   = m_sum_reg;
        m_cnt_next   = m_cnt_reg;
        m_ovf_next   = m_ovf_reg;
        m_last_next  = m_last_reg;
        a_we         = 1'b0;
        b_we         = 1'b0;

        case (state_reg)
            stma_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        stma_pkg::CMD_HDR_A:
                        begin
                            a_rows_next  = in_ent.row;
                            a_cols_next  = in_ent.col;
                            a_count_next = '0;
                        end
                        stma_pkg::CMD_HDR_B:
                        begin
                            b_rows_next  = in_ent.row;
                            b_cols_next  = in_ent.col;
                            b_count_next = '0;
                        end
                        stma_pkg::CMD_TERM_A:
                        begin
                            if (a_count_reg == CW'(MAX_TERMS))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                a_we         = 1'b1;
                                a_count_next = a_count_reg + 1'b1;
                            end
                        end
                        stma_pkg::CMD_TERM_B:
                        begin
                            if (b_count_reg == CW'(MAX_TERMS))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                b_we         = 1'b1;
                                b_count_next = b_count_reg + 1'b1;
                            end
                        end
                        stma_pkg::CMD_START:
                        begin
                            state_next = stma_pkg::S_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            stma_pkg::S_START:
            begin
                i_next = '0;
                j_next = '0;
                n_next = '0;
                if ((a_rows_reg != b_rows_reg) || (a_cols_reg != b_cols_reg))
                begin
                    if (slot_free)
                    begin
                        m_valid_next = 1'b1;
                        m_kind_next  = stma_pkg::KIND_INCOMP;
                        m_row_next   = '0;
                        m_col_next   = '0;
                        m_sum_next   = '0;
                        m_cnt_next   = '0;
                        m_ovf_next   = dropped_reg;
                        m_last_next  = 1'b1;
                        dropped_next = 1'b0;
                        state_next   = stma_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = stma_pkg::S_RD;
                end
            end

            stma_pkg::S_RD:
            begin
                if (have_a || have_b)
                begin
                    state_next = stma_pkg::S_MUL;
                end
                else if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = stma_pkg::KIND_SUMMARY;
                    m_row_next   = a_rows_reg;
                    m_col_next   = a_cols_reg;
                    m_sum_next   = '0;
                    m_cnt_next   = n_reg;
                    m_ovf_next   = dropped_reg;
                    m_last_next  = 1'b1;
                    dropped_next = 1'b0;
                    state_next   = stma_pkg::S_IDLE;
                end
            end

            stma_pkg::S_MUL:
            begin
                xi_next    = {1'b0, prod_a} + {{(LW-DW){1'b0}}, a_ent.col};
                yi_next    = {1'b0, prod_b} + {{(LW-DW){1'b0}}, b_ent.col};
                state_next = stma_pkg::S_CMP;
            end

            stma_pkg::S_CMP:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_kind_next  = stma_pkg::KIND_TERM;
                    m_row_next   = use_a ? a_ent.row : b_ent.row;
                    m_col_next   = use_a ? a_ent.col : b_ent.col;
                    m_sum_next   = a_ext + b_ext;
                    m_cnt_next   = '0;
                    m_ovf_next   = dropped_reg;
                    m_last_next  = 1'b0;
                    i_next       = i_reg + CW'(use_a);
                    j_next       = j_reg + CW'(use_b);
                    n_next       = n_reg + 1'b1;
                    state_next   = stma_pkg::S_RD;
                end
            end

            default:
            begin
                state_next = stma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stma_pkg::S_IDLE;
            a_rows_reg  <= '0;
            a_cols_reg  <= '0;
            b_rows_reg  <= '0;
            b_cols_reg  <= '0;
            a_count_reg <= '0;
            b_count_reg <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_rows_reg  <= a_rows_next;
            a_cols_reg  <= a_cols_next;
            b_rows_reg  <= b_rows_next;
            b_cols_reg  <= b_cols_next;
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xi_reg     <= xi_next;
        yi_reg     <= yi_next;
        m_kind_reg <= m_kind_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_sum_reg  <= m_sum_next;
        m_cnt_reg  <= m_cnt_next;
        m_ovf_reg  <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == stma_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {m_ovf_reg, m_cnt_reg, m_sum_reg, m_col_reg, m_row_reg};

    // pointers and term count are stale until the start state has cleared them
    logic in_merge, counts_ok, ptrs_ok, terms_ok, summary_due, summary_out;

    assign in_merge    = (state_reg != stma_pkg::S_IDLE) && (state_reg != stma_pkg::S_START);
    assign counts_ok   = (a_count_reg <= CW'(MAX_TERMS)) && (b_count_reg <= CW'(MAX_TERMS));
    assign ptrs_ok     = (i_reg <= a_count_reg) && (j_reg <= b_count_reg);
    assign terms_ok    = (n_reg <= (6'(a_count_reg) + 6'(b_count_reg)));
    assign summary_due = (state_reg == stma_pkg::S_RD) && !have_a && !have_b && slot_free;
    assign summary_out = (state_reg == stma_pkg::S_IDLE) && m_tvalid && m_tlast && !dropped_reg;

    `STMA_ASSERT(a_count_bound, counts_ok, "store count beyond capacity")
    `STMA_ASSERT(ptr_bound, !in_merge || ptrs_ok, "merge pointer past store count")
    `STMA_ASSERT(term_count_bound, !in_merge || terms_ok, "more terms than loaded")
    `STMA_ASSERT_NEXT(summary_ends_run, summary_due, summary_out, "summary did not end the run")

endmodule

`default_nettype wire
